// ===== src/matrix_multiply_accumulate_macros.svh =====
// Assertion macros for the matrix multiply-accumulate block
`ifndef MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH
`define MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH

`define MMA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define MMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mma_pkg;
  localparam int unsigned ValW  = 32;
  localparam int unsigned SideW = 3;
  localparam int unsigned Cells = 64;
  localparam int unsigned AddrW = 6;
  localparam logic [ValW-1:0] OneQ16 = 32'h0001_0000;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_LOAD_C = 2'd2,
    OP_RUN    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_M_ROWS = 3'd0,
    REG_N_COLS = 3'd1,
    REG_K_DEPTH = 3'd2,
    REG_TRANS_A = 3'd3,
    REG_TRANS_B = 3'd4,
    REG_ALPHA = 3'd5,
    REG_BETA = 3'd6
  } reg_e;

  function automatic logic [ValW-1:0] sat_round(input logic signed [79:0] x);
    logic signed [79:0] r;
    begin
      r = x + 80'sd32768;
      if (r[79:47] == {33{1'b0}} || r[79:47] == {33{1'b1}}) begin
        sat_round = r[47:16];
      end else if (r[79]) begin
        sat_round = 32'h8000_0000;
      end else begin
        sat_round = 32'h7FFF_FFFF;
      end
    end
  endfunction
endpackage
`default_nettype wire

// ===== src/mma_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mma_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire [$clog2(Depth)-1:0]   waddr_i,
  input  wire [Width-1:0]           wdata_i,
  input  wire [$clog2(Depth)-1:0]   raddr_i,
  output logic [Width-1:0]          rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== src/matrix_multiply_accumulate.sv =====
// Load transaction: one accepted per cycle while no run is in progress.
// Run transaction: per result element, C read, beta scale, then for each k an A read, alpha
// scale and product into the accumulator on the shared multiplier, then a step to round and
// present; an empty shape goes straight from accept to the present step for its marker.
// Intake stalls until the last result is presented; a held result delays the next element.
// Reset: registers return to m=n=k=8, alpha=1.0, beta=0; stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "matrix_multiply_accumulate_macros.svh"
module matrix_multiply_accumulate #(
  parameter int unsigned MAX_DIM = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_index_i,
  input  wire  [31:0] cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  operation_i,
  input  wire  [2:0]  row_i,
  input  wire  [2:0]  col_i,
  input  wire  signed [31:0] value_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [2:0]  row_res_o,
  output logic [2:0]  col_res_o,
  output logic signed [31:0] value_res_o,
  output logic        last_o,
  output logic        empty_res_o
);
  import mma_pkg::*;

  localparam logic [3:0] MaxDim = 4'(MAX_DIM);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CREAD, ST_CMUL, ST_AREAD, ST_ASCALE, ST_PROD, ST_EMIT
  } state_e;

  state_e state_q;
  logic [3:0] m_q, n_q, k_q;
  logic ta_q, tb_q;
  logic [31:0] alpha_q, beta_q;
  logic [2:0] i_q, j_q, p_q;
  logic [3:0] mc_q, nc_q, kc_q;
  logic signed [79:0] acc_q;
  logic signed [31:0] as_q;
  logic empty_q;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  logic [AddrW-1:0] a_ra, b_ra, c_ra, a_wa, b_wa, c_wa;
  logic a_we, b_we, c_we;
  logic [31:0] a_rd, b_rd, c_rd, c_wd;

  assign a_we = in_acc && operation_i == OP_LOAD_A;
  assign b_we = in_acc && operation_i == OP_LOAD_B;
  assign a_wa = ta_q ? {col_i, row_i} : {row_i, col_i};
  assign b_wa = tb_q ? {col_i, row_i} : {row_i, col_i};
  assign a_ra = {i_q, p_q};
  assign b_ra = {p_q, j_q};
  assign c_ra = {i_q, j_q};

  logic emit_go;
  logic [31:0] res;
  assign res = sat_round(acc_q);
  assign emit_go = (state_q == ST_EMIT) && !out_valid_o;
  assign c_we = (in_acc && operation_i == OP_LOAD_C) || (emit_go && !empty_q);
  assign c_wa = in_acc ? {row_i, col_i} : {i_q, j_q};
  assign c_wd = in_acc ? 32'(value_i) : res;

  mma_ram #(.Width(32), .Depth(Cells)) u_a (.clk_i, .we_i(a_we), .waddr_i(a_wa),
    .wdata_i(value_i), .raddr_i(a_ra), .rdata_o(a_rd));
  mma_ram #(.Width(32), .Depth(Cells)) u_b (.clk_i, .we_i(b_we), .waddr_i(b_wa),
    .wdata_i(value_i), .raddr_i(b_ra), .rdata_o(b_rd));
  mma_ram #(.Width(32), .Depth(Cells)) u_c (.clk_i, .we_i(c_we), .waddr_i(c_wa),
    .wdata_i(c_wd), .raddr_i(c_ra), .rdata_o(c_rd));

  // shared multiplier
  logic signed [31:0] mul_x, mul_y;
  logic signed [63:0] mul_p;
  always_comb begin
    case (state_q)
      ST_CMUL:   begin mul_x = beta_q;  mul_y = c_rd; end
      ST_ASCALE: begin mul_x = alpha_q; mul_y = a_rd; end
      default:   begin mul_x = as_q;    mul_y = b_rd; end
    endcase
  end
  assign mul_p = mul_x * mul_y;

  logic last_elem;
  assign last_elem = ({1'b0, i_q} == mc_q - 4'd1) && ({1'b0, j_q} == nc_q - 4'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      m_q <= 4'd8; n_q <= 4'd8; k_q <= 4'd8;
      ta_q <= 1'b0; tb_q <= 1'b0;
      alpha_q <= OneQ16; beta_q <= '0;
      out_valid_o <= 1'b0;
      i_q <= '0; j_q <= '0; p_q <= '0;
      mc_q <= '0; nc_q <= '0; kc_q <= '0;
      acc_q <= '0; as_q <= '0; empty_q <= 1'b0;
      row_res_o <= '0; col_res_o <= '0; value_res_o <= '0;
      last_o <= 1'b0; empty_res_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_M_ROWS:  m_q <= cfg_data_i[3:0];
          REG_N_COLS:  n_q <= cfg_data_i[3:0];
          REG_K_DEPTH: k_q <= cfg_data_i[3:0];
          REG_TRANS_A: ta_q <= cfg_data_i[0];
          REG_TRANS_B: tb_q <= cfg_data_i[0];
          REG_ALPHA:   alpha_q <= cfg_data_i;
          REG_BETA:    beta_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_acc && operation_i == OP_RUN) begin
            mc_q <= (m_q > MaxDim) ? MaxDim : m_q;
            nc_q <= (n_q > MaxDim) ? MaxDim : n_q;
            kc_q <= (k_q > MaxDim) ? MaxDim : k_q;
            i_q <= '0; j_q <= '0; p_q <= '0;
            acc_q <= '0;
            if (m_q == 4'd0 || n_q == 4'd0) begin
              empty_q <= 1'b1;
              state_q <= ST_EMIT;
            end else begin
              empty_q <= 1'b0;
              state_q <= ST_CREAD;
            end
          end
        end
        ST_CREAD: begin
          acc_q <= '0;
          p_q <= '0;
          state_q <= ST_CMUL;
        end
        ST_CMUL: begin
          if (beta_q == OneQ16) acc_q <= 80'(signed'(c_rd)) <<< 16;
          else if (beta_q != '0) acc_q <= 80'(mul_p);
          state_q <= (kc_q == 4'd0) ? ST_EMIT : ST_AREAD;
        end
        ST_AREAD: state_q <= ST_ASCALE;
        ST_ASCALE: begin
          as_q <= sat_round(80'(mul_p));
          state_q <= ST_PROD;
        end
        ST_PROD: begin
          acc_q <= acc_q + 80'(mul_p);
          if ({1'b0, p_q} == kc_q - 4'd1) state_q <= ST_EMIT;
          else begin
            p_q <= p_q + 3'd1;
            state_q <= ST_AREAD;
          end
        end
        ST_EMIT: begin
          if (!out_valid_o) begin
            out_valid_o <= 1'b1;
            row_res_o <= empty_q ? 3'd0 : i_q;
            col_res_o <= empty_q ? 3'd0 : j_q;
            value_res_o <= empty_q ? 32'sd0 : res;
            last_o <= empty_q || last_elem;
            empty_res_o <= empty_q;
            if (empty_q || last_elem) state_q <= ST_IDLE;
            else begin
              state_q <= ST_CREAD;
              if ({1'b0, j_q} == nc_q - 4'd1) begin
                j_q <= '0;
                i_q <= i_q + 3'd1;
              end else j_q <= j_q + 3'd1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `MMA_ASSERT_IMPL(a_busy_stall, clk_i, rst_ni, state_q != ST_IDLE, in_stall_o,
    "intake open during run")
  `MMA_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(value_res_o), "stalled result changed")
  `MMA_ASSERT_IMPL(a_empty_last, clk_i, rst_ni, out_valid_o && empty_res_o, last_o,
    "empty marker without last")
endmodule
`default_nettype wire

// ===== verif/mma_checker.sv =====
`timescale 1ns / 1ps
module mma_checker (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_index_i,
  input  wire  [31:0] cfg_data_i,
  input  wire         in_valid_i,
  input  wire         in_stall_i,
  input  wire  [1:0]  operation_i,
  input  wire  [2:0]  row_i,
  input  wire  [2:0]  col_i,
  input  wire  [31:0] value_i,
  input  wire         out_valid_i,
  input  wire         out_stall_i,
  input  wire  [2:0]  row_res_i,
  input  wire  [2:0]  col_res_i,
  input  wire  [31:0] value_res_i,
  input  wire         last_i,
  input  wire         empty_res_i,
  output int          errors_o,
  output int          pending_o,
  output int          runs_o,
  output int          results_o
);
  import mma_pkg::*;

  typedef struct packed {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    logic        last;
    logic        empty;
  } c_elem_t;

  c_elem_t            c_elem_q[$];
  logic signed [31:0] a_mem [Cells];
  logic signed [31:0] b_mem [Cells];
  logic signed [31:0] c_mem [Cells];
  logic [3:0]         m_rows, n_cols, k_depth;
  logic               trans_a, trans_b;
  logic signed [31:0] alpha_q, beta_q;

  function automatic int clamp_dim(logic [3:0] d);
    return (d > 4'd8) ? 8 : int'(d);
  endfunction

  function automatic logic signed [31:0] scale_by_alpha(logic signed [31:0] a);
    longint signed p;
    p = longint'(alpha_q) * longint'(a);
    p = (p + 64'sd32768) >>> 16;
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    return p[31:0];
  endfunction

  function automatic logic signed [31:0] round_sat(logic signed [71:0] acc);
    logic signed [71:0] q;
    q = (acc + 72'sd32768) >>> 16;
    if (q > 72'sd2147483647) return 32'h7FFF_FFFF;
    if (q < -72'sd2147483648) return 32'h8000_0000;
    return q[31:0];
  endfunction

  task automatic predict_run();
    int                 m, n, k;
    logic signed [71:0] acc;
    longint signed      term;
    c_elem_t            e;
    m = clamp_dim(m_rows);
    n = clamp_dim(n_cols);
    k = clamp_dim(k_depth);
    if (m == 0 || n == 0) begin
      e = '0;
      e.last = 1'b1;
      e.empty = 1'b1;
      c_elem_q.push_back(e);
      return;
    end
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = '0;
        if (beta_q != 0) begin
          term = longint'(beta_q) * longint'(c_mem[i*8+j]);
          acc = acc + term;
        end
        for (int p = 0; p < k; p++) begin
          term = longint'(scale_by_alpha(a_mem[i*8+p])) * longint'(b_mem[p*8+j]);
          acc = acc + term;
        end
        e.row = i[2:0];
        e.col = j[2:0];
        e.value = round_sat(acc);
        e.last = (i == m - 1) && (j == n - 1);
        e.empty = 1'b0;
        c_mem[i*8+j] = e.value;
        c_elem_q.push_back(e);
      end
    end
  endtask

  assign pending_o = c_elem_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    c_elem_t e;
    if (!rst_ni) begin
      m_rows <= 4'd8;
      n_cols <= 4'd8;
      k_depth <= 4'd8;
      trans_a <= 1'b0;
      trans_b <= 1'b0;
      alpha_q <= OneQ16;
      beta_q <= '0;
      errors_o <= 0;
      runs_o <= 0;
      results_o <= 0;
      c_elem_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (reg_e'(cfg_index_i))
          REG_M_ROWS:  m_rows <= cfg_data_i[3:0];
          REG_N_COLS:  n_cols <= cfg_data_i[3:0];
          REG_K_DEPTH: k_depth <= cfg_data_i[3:0];
          REG_TRANS_A: trans_a <= cfg_data_i[0];
          REG_TRANS_B: trans_b <= cfg_data_i[0];
          REG_ALPHA:   alpha_q <= cfg_data_i;
          REG_BETA:    beta_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        case (op_e'(operation_i))
          OP_LOAD_A: begin
            if (trans_a) a_mem[{col_i, row_i}] = value_i;
            else a_mem[{row_i, col_i}] = value_i;
          end
          OP_LOAD_B: begin
            if (trans_b) b_mem[{col_i, row_i}] = value_i;
            else b_mem[{row_i, col_i}] = value_i;
          end
          OP_LOAD_C: c_mem[{row_i, col_i}] = value_i;
          default: begin
            predict_run();
            runs_o <= runs_o + 1;
          end
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        results_o <= results_o + 1;
        if (c_elem_q.size() == 0) begin
          if (errors_o < 10)
            $display("%0t: unexpected result row %0d col %0d value %h",
                     $time, row_res_i, col_res_i, value_res_i);
          errors_o <= errors_o + 1;
        end else begin
          e = c_elem_q.pop_front();
          if (e.row !== row_res_i || e.col !== col_res_i || e.value !== value_res_i ||
              e.last !== last_i || e.empty !== empty_res_i) begin
            if (errors_o < 10)
              $display("%0t: mismatch exp r%0d c%0d v%h l%b e%b got r%0d c%0d v%h l%b e%b",
                       $time, e.row, e.col, e.value, e.last, e.empty,
                       row_res_i, col_res_i, value_res_i, last_i, empty_res_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb_matrix_multiply_accumulate.sv =====
`timescale 1ns / 1ps
module tb_matrix_multiply_accumulate;
  import mma_pkg::*;

  localparam int StallLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i = '0;
  logic [2:0]  row_i = '0;
  logic [2:0]  col_i = '0;
  logic [31:0] value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  row_res_o;
  logic [2:0]  col_res_o;
  logic [31:0] value_res_o;
  logic        last_o;
  logic        empty_res_o;

  int errors, pending, runs, results;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;

  always #5 clk_i = ~clk_i;

  matrix_multiply_accumulate dut (.*);

  mma_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_stall_i(in_stall_o), .operation_i(operation_i),
    .row_i(row_i), .col_i(col_i), .value_i(value_i),
    .out_valid_i(out_valid_o), .out_stall_i(out_stall_i),
    .row_res_i(row_res_o), .col_res_i(col_res_o), .value_res_i(value_res_o),
    .last_i(last_o), .empty_res_i(empty_res_o),
    .errors_o(errors), .pending_o(pending), .runs_o(runs), .results_o(results)
  );

  function automatic int gap_len();
    if (!gaps_on) return 0;
    if ($urandom_range(0, 19) < 17) return $urandom_range(0, 2);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
      default: return $urandom();
    endcase
  endfunction

  task automatic send(op_e op, logic [2:0] r, logic [2:0] c, logic [31:0] v);
    repeat (gap_len()) @(negedge clk_i);
    in_valid_i = 1'b1;
    operation_i = op;
    row_i = r;
    col_i = c;
    value_i = v;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic drain();
    wait (pending == 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic random_item(int run_pct);
    if ($urandom_range(0, 99) < run_pct)
      send(OP_RUN, 3'($urandom()), 3'($urandom()), $urandom());
    else
      send(op_e'($urandom_range(0, 2)), 3'($urandom()), 3'($urandom()), rand_value());
  endtask

  // hold off the result channel at random
  initial begin
    forever begin
      @(negedge clk_i);
      out_stall_i = 1'b0;
      repeat (gap_len()) @(negedge clk_i);
      out_stall_i = gaps_on && ($urandom_range(0, 3) == 0);
      if (out_stall_i) repeat (gap_len()) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("timeout with %0d results pending", pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int dim_max;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // fill every store entry so no run reads an unwritten cell
    for (int i = 0; i < Cells; i++) begin
      send(OP_LOAD_A, i[5:3], i[2:0], (i == 0) ? 32'h7FFF_FFFF : rand_value());
      send(OP_LOAD_B, i[5:3], i[2:0], (i == 0) ? 32'h8000_0000 : rand_value());
      send(OP_LOAD_C, i[5:3], i[2:0], rand_value());
    end
    send(OP_RUN, 3'd7, 3'd7, 32'hFFFF_FFFF);
    drain();

    write_reg(REG_M_ROWS, 32'd0);
    write_reg(REG_N_COLS, 32'd3);
    send(OP_RUN, 3'd0, 3'd0, 32'h0);
    drain();
    write_reg(REG_M_ROWS, 32'd2);
    write_reg(REG_N_COLS, 32'd0);
    send(OP_RUN, 3'd0, 3'd0, 32'h0);
    drain();
    write_reg(REG_M_ROWS, 32'd15);
    write_reg(REG_N_COLS, 32'd15);
    write_reg(REG_K_DEPTH, 32'd15);
    write_reg(REG_ALPHA, 32'h7FFF_FFFF);
    write_reg(REG_BETA, 32'h8000_0000);
    send(OP_RUN, 3'd0, 3'd0, 32'h0);
    drain();
    write_reg(REG_K_DEPTH, 32'd0);
    write_reg(REG_BETA, OneQ16);
    write_reg(REG_M_ROWS, 32'd3);
    write_reg(REG_N_COLS, 32'd8);
    send(OP_RUN, 3'd0, 3'd0, 32'h0);
    drain();
    write_reg(REG_TRANS_A, 32'd1);
    write_reg(REG_TRANS_B, 32'd1);
    write_reg(REG_ALPHA, 32'h8000_0000);
    write_reg(REG_BETA, 32'h7FFF_FFFF);
    write_reg(REG_K_DEPTH, 32'd8);
    send(OP_LOAD_A, 3'd1, 3'd6, 32'h0001_8000);
    send(OP_LOAD_B, 3'd7, 3'd0, 32'hFFFF_0000);
    send(OP_RUN, 3'd0, 3'd0, 32'h0);
    drain();
    write_reg(REG_ALPHA, 32'h0);
    write_reg(REG_TRANS_A, 32'd0);
    write_reg(REG_TRANS_B, 32'd0);
    send(OP_RUN, 3'd0, 3'd0, 32'h0);
    drain();

    // random phases: mostly small shapes, a few full-size ones
    for (int ph = 0; ph < 20; ph++) begin
      gaps_on = (ph % 5) != 3;
      dim_max = ($urandom_range(0, 4) == 0) ? 15 : 4;
      write_reg(REG_M_ROWS, $urandom_range(0, dim_max));
      write_reg(REG_N_COLS, $urandom_range(0, dim_max));
      write_reg(REG_K_DEPTH, $urandom_range(0, dim_max));
      write_reg(REG_TRANS_A, $urandom_range(0, 1));
      write_reg(REG_TRANS_B, $urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0: write_reg(REG_ALPHA, OneQ16);
        1: write_reg(REG_ALPHA, $urandom_range(0, 32'h4_0000) - 32'h2_0000);
        default: write_reg(REG_ALPHA, rand_value());
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(REG_BETA, 32'h0);
        1: write_reg(REG_BETA, OneQ16);
        default: write_reg(REG_BETA, rand_value());
      endcase
      for (int it = 0; it < 14; it++) random_item(15);
      drain();
    end
    gaps_on = 1'b1;

    wait (pending == 0);
    repeat (50) @(negedge clk_i);
    $display("Covered %0d runs and %0d result transactions across shape, scale and",
             runs, results);
    $display("transpose settings including empty shapes, zero depth and saturation.");
    if (errors == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/mma_pkg.sv
src/mma_ram.sv
src/matrix_multiply_accumulate.sv
verif/mma_checker.sv
verif/tb_matrix_multiply_accumulate.sv
